// File: design/bsm_pkg.sv
package bsm_pkg;

  // One input item: a bus write or a scanline tick.
  typedef struct packed {
    logic        func;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  slot;
    logic [7:0]  bank_value;
    logic [1:0]  mirror_mode;
    logic [15:0] sound_addr;
    logic [7:0]  sound_data;
    logic        irq_pulse;
  } result_t;

  // Item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Event kinds
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PATTERN = 3'd1;
  localparam logic [2:0] EV_PROGRAM = 3'd2;
  localparam logic [2:0] EV_MIRROR  = 3'd3;
  localparam logic [2:0] EV_SOUND   = 3'd4;
  localparam logic [2:0] EV_IRQ     = 3'd5;

  // Address regions, addr[15:13]
  localparam logic [2:0] REGION_CMD     = 3'b100;
  localparam logic [2:0] REGION_PARAM   = 3'b101;
  localparam logic [2:0] REGION_SOUND_C = 3'b110;
  localparam logic [2:0] REGION_SOUND_E = 3'b111;

  // Commands
  localparam logic [3:0] CMD_PRG_LOW   = 4'd8;
  localparam logic [3:0] CMD_PRG_LAST  = 4'd11;
  localparam logic [3:0] CMD_MIRROR    = 4'd12;
  localparam logic [3:0] CMD_IRQ_EN    = 4'd13;
  localparam logic [3:0] CMD_CNT_LOW   = 4'd14;
  localparam logic [3:0] CMD_CNT_HIGH  = 4'd15;

  localparam logic [2:0]  PRG_LOW_SLOT  = 3'd3;
  localparam logic [3:0]  PRG_SLOT_BIAS = 4'd5;
  localparam int unsigned PRG_BLOCK_BIT = 6;

  localparam logic [15:0] TICK_STEP = 16'd113;

  // Configuration registers
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        REG_PATCH_MODE = 1'b0;

endpackage

// File: design/bsm_decode.sv
module bsm_decode import bsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    patch_mode,
  input  item_t   item,
  input  logic    fire,
  output result_t result
);

  logic [3:0]  command_reg;
  logic [3:0]  command_reg_next;
  logic        irq_enable;
  logic        irq_enable_next;
  logic [15:0] irq_count;
  logic [15:0] irq_count_next;

  always_comb begin
    result           = '0;
    command_reg_next = command_reg;
    irq_enable_next  = irq_enable;
    irq_count_next   = irq_count;
    if (item.func == FUNC_TICK) begin
      if (irq_enable) begin
        if (irq_count <= TICK_STEP) begin
          irq_count_next    = '0;
          result.event_kind = EV_IRQ;
          result.irq_pulse  = 1'b1;
        end else begin
          irq_count_next = irq_count - TICK_STEP;
        end
      end
    end else begin
      unique case (item.addr[15:13])
        REGION_CMD: begin
          command_reg_next = item.data[3:0];
        end
        REGION_PARAM: begin
          priority if (command_reg < CMD_PRG_LOW) begin
            result.event_kind = EV_PATTERN;
            result.slot       = command_reg[2:0];
            result.bank_value = item.data;
          end else if (command_reg == CMD_PRG_LOW) begin
            // blocked in patch mode or when the data carries bit 6
            if (!patch_mode && !item.data[PRG_BLOCK_BIT]) begin
              result.event_kind = EV_PROGRAM;
              result.slot       = PRG_LOW_SLOT;
              result.bank_value = item.data;
            end
          end else if (command_reg <= CMD_PRG_LAST) begin
            result.event_kind = EV_PROGRAM;
            result.slot       = 3'(command_reg - PRG_SLOT_BIAS);
            result.bank_value = item.data;
          end else if (command_reg == CMD_MIRROR) begin
            result.event_kind  = EV_MIRROR;
            result.mirror_mode = item.data[1:0];
          end else if (command_reg == CMD_IRQ_EN) begin
            irq_enable_next = (item.data != 8'd0);
          end else if (command_reg == CMD_CNT_LOW) begin
            irq_count_next = {irq_count[15:8], item.data};
          end else begin
            irq_count_next = {item.data, irq_count[7:0]};
          end
        end
        REGION_SOUND_C, REGION_SOUND_E: begin
          result.event_kind = EV_SOUND;
          result.sound_addr = item.addr;
          result.sound_data = item.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg <= '0;
      irq_enable  <= 1'b0;
      irq_count   <= '0;
    end else if (fire) begin
      command_reg <= command_reg_next;
      irq_enable  <= irq_enable_next;
      irq_count   <= irq_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_irq_clears_count: assert property (@(posedge clk) disable iff (rst)
    fire && result.irq_pulse |=> irq_count == 16'd0)
    else $error("counter not cleared after irq");

  a_irq_needs_enable: assert property (@(posedge clk) disable iff (rst)
    result.irq_pulse |-> irq_enable && item.func == FUNC_TICK)
    else $error("irq raised without enable");
`endif

endmodule

// File: design/bsm_outreg.sv
module bsm_outreg import bsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    stall,
  output logic    valid,
  output logic    space,
  output result_t result_out
);

  // room for a new result when empty or when the held one leaves now
  assign space = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      result_out <= result_in;
    end
  end

endmodule

// File: design/bank_switch_mapper_scanline_irq.sv
// Bank-switch mapper with a scanline interrupt counter. Each input transfer
// is a CPU bus write (func 0) or a scanline tick (func 1) and gives exactly
// one result transfer. The block takes one item per clock cycle when the
// result side does not stall. An item waits in the input register until the
// result register has room, and its result is then registered there and
// presented on the result channel with result_valid high.
// Decode, the command and counter state and the 113 step subtraction sit in
// the single logic stage between those two registers. item_stall rises only
// when both registers hold items and result_stall is high. patch_mode is
// register 0 of the APB port (byte address 0); write it only while idle.
module bank_switch_mapper_scanline_irq import bsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  func,
  input  logic [15:0]           addr,
  input  logic [7:0]            data,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [2:0]            event_kind,
  output logic [2:0]            slot,
  output logic [7:0]            bank_value,
  output logic [1:0]            mirror_mode,
  output logic [15:0]           sound_addr,
  output logic [7:0]            sound_data,
  output logic                  irq_pulse
);

  logic    patch_mode;
  logic    cfg_write;
  logic    in_accept;
  item_t   item_reg;
  logic    item_reg_valid;
  logic    advance;
  logic    out_space;
  result_t result_comb;
  result_t result_reg;

  // Configuration: one register, decoded on the word address bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_mode <= 1'b0;
    end else if (cfg_write && paddr[CFG_ADDR_W-1] == REG_PATCH_MODE) begin
      patch_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_PATCH_MODE) begin
      prdata[0] = patch_mode;
    end
  end

  // Input register: advance into the result register whenever it has room.
  assign advance    = item_reg_valid && out_space;
  assign item_stall = item_reg_valid && !out_space;
  assign in_accept  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (in_accept) begin
      item_reg_valid <= 1'b1;
    end else if (advance) begin
      item_reg_valid <= 1'b0;
    end
  end

  // Hold the payload until a new transfer replaces it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_reg <= '{func: func, addr: addr, data: data};
    end
  end

  // State updates commit only when the item moves on, keeping item order.
  bsm_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .patch_mode (patch_mode),
    .item       (item_reg),
    .fire       (advance),
    .result     (result_comb)
  );

  bsm_outreg u_outreg (
    .clk        (clk),
    .rst        (rst),
    .load       (item_reg_valid),
    .result_in  (result_comb),
    .stall      (result_stall),
    .valid      (result_valid),
    .space      (out_space),
    .result_out (result_reg)
  );

  assign event_kind  = result_reg.event_kind;
  assign slot        = result_reg.slot;
  assign bank_value  = result_reg.bank_value;
  assign mirror_mode = result_reg.mirror_mode;
  assign sound_addr  = result_reg.sound_addr;
  assign sound_data  = result_reg.sound_data;
  assign irq_pulse   = result_reg.irq_pulse;

`ifndef ASSERT_OFF
  a_irq_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && irq_pulse |-> event_kind == EV_IRQ)
    else $error("irq pulse without irq event");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> item_reg_valid && result_valid && result_stall)
    else $error("input stalled with room to advance");
`endif

endmodule
